[sv/sfcs_pkg.sv]
// Package for the serial NOR flash command slave.
// It holds the opcodes, the reply constants, the configuration indexes and the reply tables.
// It depends on nothing else.
package sfcs_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_CNT_W = 3;
    localparam int CMD_IDX_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_TWO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_THREE = 1'b1;

    localparam logic [7:0] OP_PROG      = 8'h02;
    localparam logic [7:0] OP_READ      = 8'h03;
    localparam logic [7:0] OP_WRDI      = 8'h04;
    localparam logic [7:0] OP_RDSR1     = 8'h05;
    localparam logic [7:0] OP_WREN      = 8'h06;
    localparam logic [7:0] OP_RDSR3     = 8'h15;
    localparam logic [7:0] OP_ERASE_4K  = 8'h20;
    localparam logic [7:0] OP_RDSR2     = 8'h35;
    localparam logic [7:0] OP_UID       = 8'h4B;
    localparam logic [7:0] OP_ERASE_32K = 8'h52;
    localparam logic [7:0] OP_MFR_ID    = 8'h90;
    localparam logic [7:0] OP_JEDEC_ID  = 8'h9F;
    localparam logic [7:0] OP_WAKE      = 8'hAB;
    localparam logic [7:0] OP_SLEEP     = 8'hB9;
    localparam logic [7:0] OP_ERASE_64K = 8'hD8;

    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] MFR_CODE   = 8'hEF;
    localparam logic [7:0] DEV_CODE   = 8'h14;
    localparam logic [7:0] JEDEC_TYPE = 8'h40;
    localparam logic [7:0] JEDEC_CAP  = 8'h15;
    localparam logic [7:0] SR1_WEL    = 8'h02;
    localparam logic [7:0] SR1_CLEAR  = 8'h00;

    localparam logic [7:0] UID_BYTES [8] = '{8'h01, 8'h23, 8'h45, 8'h67,
                                             8'h89, 8'hAB, 8'hCD, 8'hEF};

    typedef enum logic [2:0] {
        RPL_NONE,
        RPL_UID,
        RPL_MFR,
        RPL_JEDEC,
        RPL_WAKE
    } reply_kind_t;

    function automatic logic [3:0] reply_len(input reply_kind_t kind);
        logic [3:0] len;
        case (kind)
            RPL_UID:   len = 4'd12;
            RPL_MFR:   len = 4'd2;
            RPL_JEDEC: len = 4'd3;
            RPL_WAKE:  len = 4'd4;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] reply_byte(input reply_kind_t kind, input logic [3:0] pos);
        logic [3:0] upos;
        logic [7:0] b;
        upos = pos - 4'd4;
        b    = FILL_BYTE;
        case (kind)
            RPL_UID:
            begin
                if (pos >= 4'd4)
                begin
                    b = UID_BYTES[upos[2:0]];
                end
            end
            RPL_MFR:
            begin
                b = (pos == 4'd0) ? MFR_CODE : DEV_CODE;
            end
            RPL_JEDEC:
            begin
                case (pos)
                    4'd0:    b = MFR_CODE;
                    4'd1:    b = JEDEC_TYPE;
                    default: b = JEDEC_CAP;
                endcase
            end
            RPL_WAKE:
            begin
                if (pos == 4'd3)
                begin
                    b = DEV_CODE;
                end
            end
            default: b = FILL_BYTE;
        endcase
        return b;
    endfunction

endpackage

[sv/sfcs_if.sv]
// Channel interfaces of the serial NOR flash command slave: input items, results, configuration.
// Each carries valid, ready and its payload; a transfer happens when both are high.
// Depends on sfcs_pkg for the configuration index width.
interface sfcs_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] mosi_byte;

    modport source (output valid, output command, output mosi_byte, input ready);
    modport sink (input valid, input command, input mosi_byte, output ready);
endinterface

interface sfcs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;

    modport source (output valid, output miso_byte, input ready);
    modport sink (input valid, input miso_byte, output ready);
endinterface

interface sfcs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfcs_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/spi_flash_command_slave.sv]
// Top level of the serial NOR flash command slave: command decode, reply queue and flash array.
// Depends on sfcs_pkg and the channel interfaces in sfcs_if.sv.
//
// Channel  Direction  Payload                Transfer
// item     in         command, mosi_byte     item.valid & item.ready
// result   out        miso_byte              result.valid & result.ready
// cfg      in         index, data            cfg.valid & cfg.ready (ready is always high)
//
// One item is taken per cycle while the result channel keeps up; its result is registered in the
// read stage, beside the flash array's synchronous read, and then in the output register.
// After reset the array is swept to 0xFF one byte per cycle, through all MEM_BYTES addresses,
// while no item is taken; configuration writes are taken throughout.
// A stalled result holds the output register, and items keep flowing until the read stage fills.
module spi_flash_command_slave #(
    parameter int MEM_BYTES   = 65536,
    parameter int REPLY_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sfcs_item_if.sink            item,
    sfcs_result_if.source        result,
    sfcs_cfg_if.sink             cfg
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int RCW = $clog2(REPLY_DEPTH + 1);
    localparam logic [24:0]    MEM_LIMIT  = 25'(MEM_BYTES);
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(MEM_BYTES - 1);
    localparam logic [RCW:0]   REPLY_FULL = (RCW + 1)'(REPLY_DEPTH);
    localparam logic [sfcs_pkg::CMD_CNT_W-1:0] CMD_FULL = sfcs_pkg::CMD_CNT_W'(sfcs_pkg::CMD_DEPTH);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_PROG,
        MODE_SR1,
        MODE_SR2,
        MODE_SR3
    } mode_t;

    logic [7:0] flash_mem [MEM_BYTES];

    mode_t                          mode_reg, mode_next;
    logic [23:0]                    addr_reg, addr_next;
    logic                           wel_reg, wel_next;
    logic                           asleep_reg, asleep_next;
    logic [7:0]                     cmd_reg [sfcs_pkg::CMD_DEPTH];
    logic [7:0]                     cmd_next [sfcs_pkg::CMD_DEPTH];
    logic [sfcs_pkg::CMD_CNT_W-1:0] cmd_cnt_reg, cmd_cnt_next, cnt1;
    logic [7:0]                     rq_reg [REPLY_DEPTH];
    logic [7:0]                     rq_next [REPLY_DEPTH];
    logic [RCW-1:0]                 rc_reg, rc_next, rc1;
    logic [7:0]                     status_two_reg, status_three_reg;
    logic                           clearing_reg;
    logic [AW-1:0]                  clr_addr_reg;
    logic                           p1_valid_reg, p1_mem_reg;
    logic [7:0]                     p1_byte_reg, rd_data_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;

    logic                           accept, p1_adv, in_range, upd_bufs;
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr;
    logic [7:0]                     mem_wdata, rx, op;
    sfcs_pkg::reply_kind_t          kind;
    logic [3:0]                     rlen;
    logic [RCW:0]                   posw, rsum;

    assign p1_adv     = !out_valid_reg || result.ready;
    assign item.ready = !clearing_reg && (!p1_valid_reg || p1_adv);
    assign accept     = item.valid && item.ready;
    assign in_range   = {1'b0, addr_reg} < MEM_LIMIT;
    assign cfg.ready  = 1'b1;

    assign result.valid     = out_valid_reg;
    assign result.miso_byte = out_byte_reg;

    assign mem_re    = accept && !item.command && (mode_reg == MODE_READ) && in_range;
    assign mem_we    = clearing_reg || (accept && !item.command && (mode_reg == MODE_PROG)
                                        && in_range);
    assign mem_waddr = clearing_reg ? clr_addr_reg : addr_reg[AW-1:0];
    assign mem_wdata = clearing_reg ? sfcs_pkg::FILL_BYTE : item.mosi_byte;

    always_comb
    begin
        mode_next    = mode_reg;
        addr_next    = addr_reg;
        wel_next     = wel_reg;
        asleep_next  = asleep_reg;
        cmd_cnt_next = cmd_cnt_reg;
        rc_next      = rc_reg;
        upd_bufs     = 1'b0;
        rx           = sfcs_pkg::FILL_BYTE;
        kind         = sfcs_pkg::RPL_NONE;
        rlen         = 4'd0;
        posw         = '0;
        rsum         = '0;
        cnt1         = cmd_cnt_reg;
        rc1          = rc_reg;
        cmd_next     = cmd_reg;
        rq_next      = rq_reg;

        if (cmd_cnt_reg < CMD_FULL)
        begin
            cmd_next[cmd_cnt_reg[sfcs_pkg::CMD_IDX_W-1:0]] = item.mosi_byte;
            cnt1 = cmd_cnt_reg + 1'b1;
        end
        if (rc_reg != '0)
        begin
            rc1 = rc_reg - 1'b1;
            for (int i = 0; i < REPLY_DEPTH - 1; i++)
            begin
                rq_next[i] = rq_reg[i + 1];
            end
        end
        op = cmd_next[0];

        if (item.command)
        begin
            cmd_cnt_next = '0;
            rc_next      = '0;
            mode_next    = MODE_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_READ:
                begin
                    addr_next = addr_reg + 24'd1;
                end
                MODE_PROG:
                begin
                    addr_next = {addr_reg[23:8], addr_reg[7:0] + 8'd1};
                end
                MODE_SR1:
                begin
                    rx = wel_reg ? sfcs_pkg::SR1_WEL : sfcs_pkg::SR1_CLEAR;
                end
                MODE_SR2:
                begin
                    rx = status_two_reg;
                end
                MODE_SR3:
                begin
                    rx = status_three_reg;
                end
                default:
                begin
                    upd_bufs     = 1'b1;
                    cmd_cnt_next = cnt1;
                    rc_next      = rc1;
                    if (rc_reg != '0)
                    begin
                        rx = rq_reg[0];
                    end
                    if (asleep_reg && op != sfcs_pkg::OP_WAKE)
                    begin
                        rx = sfcs_pkg::FILL_BYTE;
                    end
                    else
                    begin
                        unique case (op) inside
                            sfcs_pkg::OP_ERASE_4K, sfcs_pkg::OP_ERASE_32K,
                            sfcs_pkg::OP_ERASE_64K, sfcs_pkg::OP_PROG, sfcs_pkg::OP_READ:
                            begin
                                if (cnt1 == CMD_FULL)
                                begin
                                    addr_next    = {cmd_next[1], cmd_next[2], cmd_next[3]};
                                    cmd_cnt_next = '0;
                                    if (op == sfcs_pkg::OP_READ)
                                    begin
                                        mode_next = MODE_READ;
                                    end
                                    else if (op == sfcs_pkg::OP_PROG)
                                    begin
                                        mode_next = MODE_PROG;
                                    end
                                    else
                                    begin
                                        mode_next = MODE_IDLE;
                                    end
                                end
                            end
                            sfcs_pkg::OP_MFR_ID:
                            begin
                                if (cnt1 == CMD_FULL)
                                begin
                                    cmd_cnt_next = '0;
                                    kind         = sfcs_pkg::RPL_MFR;
                                end
                            end
                            sfcs_pkg::OP_RDSR1, sfcs_pkg::OP_RDSR2, sfcs_pkg::OP_RDSR3,
                            sfcs_pkg::OP_UID, sfcs_pkg::OP_JEDEC_ID, sfcs_pkg::OP_WAKE,
                            sfcs_pkg::OP_WRDI, sfcs_pkg::OP_WREN, sfcs_pkg::OP_SLEEP:
                            begin
                                cmd_cnt_next = cnt1 - 1'b1;
                                for (int j = 0; j < sfcs_pkg::CMD_DEPTH - 1; j++)
                                begin
                                    cmd_next[j] = cmd_next[j + 1];
                                end
                                unique case (op)
                                    sfcs_pkg::OP_RDSR1:    mode_next   = MODE_SR1;
                                    sfcs_pkg::OP_RDSR2:    mode_next   = MODE_SR2;
                                    sfcs_pkg::OP_RDSR3:    mode_next   = MODE_SR3;
                                    sfcs_pkg::OP_UID:      kind        = sfcs_pkg::RPL_UID;
                                    sfcs_pkg::OP_JEDEC_ID: kind        = sfcs_pkg::RPL_JEDEC;
                                    sfcs_pkg::OP_WRDI:     wel_next    = 1'b0;
                                    sfcs_pkg::OP_WREN:     wel_next    = 1'b1;
                                    sfcs_pkg::OP_SLEEP:    asleep_next = 1'b1;
                                    default:
                                    begin
                                        asleep_next = 1'b0;
                                        kind        = sfcs_pkg::RPL_WAKE;
                                    end
                                endcase
                            end
                            default:
                            begin
                                cmd_cnt_next = '0;
                            end
                        endcase
                    end

                    rlen = sfcs_pkg::reply_len(kind);
                    for (int i = 0; i < REPLY_DEPTH; i++)
                    begin
                        posw = (RCW + 1)'(i) - {1'b0, rc1};
                        if (((RCW + 1)'(i) >= {1'b0, rc1}) && (posw < (RCW + 1)'(rlen)))
                        begin
                            rq_next[i] = sfcs_pkg::reply_byte(kind, posw[3:0]);
                        end
                    end
                    rsum = {1'b0, rc1} + (RCW + 1)'(rlen);
                    if (rsum > REPLY_FULL)
                    begin
                        rc_next = REPLY_FULL[RCW-1:0];
                    end
                    else
                    begin
                        rc_next = rsum[RCW-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            addr_reg         <= '0;
            wel_reg          <= 1'b0;
            asleep_reg       <= 1'b0;
            cmd_cnt_reg      <= '0;
            rc_reg           <= '0;
            status_two_reg   <= '0;
            status_three_reg <= '0;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            p1_valid_reg     <= 1'b0;
            p1_mem_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    sfcs_pkg::CFG_STATUS_TWO:   status_two_reg   <= cfg.data;
                    sfcs_pkg::CFG_STATUS_THREE: status_three_reg <= cfg.data;
                    default:                    status_two_reg   <= status_two_reg;
                endcase
            end
            if (accept)
            begin
                mode_reg    <= mode_next;
                addr_reg    <= addr_next;
                wel_reg     <= wel_next;
                asleep_reg  <= asleep_next;
                cmd_cnt_reg <= cmd_cnt_next;
                rc_reg      <= rc_next;
                p1_mem_reg  <= mem_re;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && upd_bufs)
        begin
            cmd_reg <= cmd_next;
            rq_reg  <= rq_next;
        end
        if (accept)
        begin
            p1_byte_reg <= rx;
        end
        if (p1_adv && p1_valid_reg)
        begin
            out_byte_reg <= p1_mem_reg ? rd_data_reg : p1_byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flash_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= flash_mem[addr_reg[AW-1:0]];
        end
    end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the serial NOR flash command slave.
// It drives byte exchanges and deselects, predicts every MISO byte and checks each result transfer.
// Depends on sfcs_pkg, the channel interfaces in sfcs_if.sv and spi_flash_command_slave.
`timescale 1ns / 1ps

module tb_top;

    localparam int MEM_SIZE      = 65536;
    localparam int REPLY_LIMIT   = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        FM_IDLE,
        FM_READ,
        FM_PROGRAM,
        FM_STATUS1,
        FM_STATUS2,
        FM_STATUS3
    } flash_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    sfcs_item_if   item_ch ();
    sfcs_result_if result_ch ();
    sfcs_cfg_if    cfg_ch ();

    spi_flash_command_slave #(
        .MEM_BYTES   (MEM_SIZE),
        .REPLY_DEPTH (REPLY_LIMIT)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    flash_mode_t fm_mode;
    logic [23:0] fm_addr;
    logic        fm_wel;
    logic        fm_asleep;
    logic [7:0]  cmd_buf [sfcs_pkg::CMD_DEPTH];
    int          cmd_len;
    logic [7:0]  reply_fifo [$];
    logic [7:0]  flash_mem [MEM_SIZE];
    logic [7:0]  status_two_reg;
    logic [7:0]  status_three_reg;

    logic [7:0]  expected_miso [$];
    logic [7:0]  checked_want;
    int          failure_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          sender_max_gap = 3;
    int          hold_request = 0;
    int          hold_left = 0;
    int          stall_phase = 0;
    logic [31:0] stall_pattern = '0;
    int          watchdog_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_flash_model();
        int i;
        fm_mode          = FM_IDLE;
        fm_addr          = '0;
        fm_wel           = 1'b0;
        fm_asleep        = 1'b0;
        cmd_len          = 0;
        status_two_reg   = 8'h00;
        status_three_reg = 8'h00;
        reply_fifo.delete();
        for (i = 0; i < MEM_SIZE; i++)
        begin
            flash_mem[i] = sfcs_pkg::FILL_BYTE;
        end
    endfunction

    function automatic void drop_command_bytes(input int n);
        int i;
        if (n >= cmd_len)
        begin
            cmd_len = 0;
        end
        else
        begin
            for (i = 0; i < cmd_len - n; i++)
            begin
                cmd_buf[i] = cmd_buf[i + n];
            end
            cmd_len -= n;
        end
    endfunction

    function automatic void queue_reply(input logic [7:0] b);
        if (reply_fifo.size() < REPLY_LIMIT)
        begin
            reply_fifo.push_back(b);
        end
    endfunction

    function automatic logic [7:0] decode_idle_byte(input logic [7:0] tx);
        logic [7:0] rx;
        logic [7:0] op;
        int         i;
        rx = sfcs_pkg::FILL_BYTE;
        if (cmd_len < sfcs_pkg::CMD_DEPTH)
        begin
            cmd_buf[cmd_len] = tx;
            cmd_len++;
        end
        if (reply_fifo.size() > 0)
        begin
            rx = reply_fifo.pop_front();
        end
        op = cmd_buf[0];
        if (fm_asleep && op != sfcs_pkg::OP_WAKE)
        begin
            return sfcs_pkg::FILL_BYTE;
        end
        case (op)
            sfcs_pkg::OP_ERASE_4K, sfcs_pkg::OP_ERASE_32K, sfcs_pkg::OP_ERASE_64K,
            sfcs_pkg::OP_PROG, sfcs_pkg::OP_READ:
            begin
                if (cmd_len >= sfcs_pkg::CMD_DEPTH)
                begin
                    fm_addr = {cmd_buf[1], cmd_buf[2], cmd_buf[3]};
                    if (op == sfcs_pkg::OP_READ)
                    begin
                        fm_mode = FM_READ;
                    end
                    else if (op == sfcs_pkg::OP_PROG)
                    begin
                        fm_mode = FM_PROGRAM;
                    end
                    else
                    begin
                        fm_mode = FM_IDLE;
                    end
                    drop_command_bytes(sfcs_pkg::CMD_DEPTH);
                end
            end
            sfcs_pkg::OP_RDSR1:
            begin
                fm_mode = FM_STATUS1;
                drop_command_bytes(1);
            end
            sfcs_pkg::OP_RDSR2:
            begin
                fm_mode = FM_STATUS2;
                drop_command_bytes(1);
            end
            sfcs_pkg::OP_RDSR3:
            begin
                fm_mode = FM_STATUS3;
                drop_command_bytes(1);
            end
            sfcs_pkg::OP_UID:
            begin
                drop_command_bytes(1);
                for (i = 0; i < 4; i++)
                begin
                    queue_reply(sfcs_pkg::FILL_BYTE);
                end
                for (i = 0; i < 8; i++)
                begin
                    queue_reply(sfcs_pkg::UID_BYTES[i]);
                end
            end
            sfcs_pkg::OP_MFR_ID:
            begin
                if (cmd_len >= sfcs_pkg::CMD_DEPTH)
                begin
                    drop_command_bytes(sfcs_pkg::CMD_DEPTH);
                    queue_reply(sfcs_pkg::MFR_CODE);
                    queue_reply(sfcs_pkg::DEV_CODE);
                end
            end
            sfcs_pkg::OP_JEDEC_ID:
            begin
                drop_command_bytes(1);
                queue_reply(sfcs_pkg::MFR_CODE);
                queue_reply(sfcs_pkg::JEDEC_TYPE);
                queue_reply(sfcs_pkg::JEDEC_CAP);
            end
            sfcs_pkg::OP_WAKE:
            begin
                fm_asleep = 1'b0;
                drop_command_bytes(1);
                for (i = 0; i < 3; i++)
                begin
                    queue_reply(sfcs_pkg::FILL_BYTE);
                end
                queue_reply(sfcs_pkg::DEV_CODE);
            end
            sfcs_pkg::OP_WRDI:
            begin
                fm_wel = 1'b0;
                drop_command_bytes(1);
            end
            sfcs_pkg::OP_WREN:
            begin
                fm_wel = 1'b1;
                drop_command_bytes(1);
            end
            sfcs_pkg::OP_SLEEP:
            begin
                fm_asleep = 1'b1;
                drop_command_bytes(1);
            end
            default:
            begin
                cmd_len = 0;
            end
        endcase
        return rx;
    endfunction

    function automatic logic [7:0] predict_miso(input logic deselect, input logic [7:0] tx);
        logic [7:0] rx;
        rx = sfcs_pkg::FILL_BYTE;
        if (deselect)
        begin
            cmd_len = 0;
            reply_fifo.delete();
            fm_mode = FM_IDLE;
        end
        else
        begin
            case (fm_mode)
                FM_READ:
                begin
                    if (fm_addr < MEM_SIZE)
                    begin
                        rx = flash_mem[fm_addr];
                    end
                    fm_addr = fm_addr + 24'd1;
                end
                FM_PROGRAM:
                begin
                    if (fm_addr < MEM_SIZE)
                    begin
                        flash_mem[fm_addr] = tx;
                    end
                    fm_addr[7:0] = fm_addr[7:0] + 8'd1;
                end
                FM_STATUS1: rx = fm_wel ? sfcs_pkg::SR1_WEL : sfcs_pkg::SR1_CLEAR;
                FM_STATUS2: rx = status_two_reg;
                FM_STATUS3: rx = status_three_reg;
                default:    rx = decode_idle_byte(tx);
            endcase
        end
        return rx;
    endfunction

    function automatic logic [23:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return {14'd0, 10'($urandom_range(0, 1023))};
        end
        if (r < 70)
        begin
            return {14'd0, 2'($urandom_range(0, 3)), 4'hF, 4'($urandom_range(0, 15))};
        end
        if (r < 82)
        begin
            return {8'd0, 16'($urandom)};
        end
        if (r < 94)
        begin
            return {8'($urandom_range(1, 255)), 16'($urandom)};
        end
        return {20'hFFFFF, 4'($urandom_range(0, 15))};
    endfunction

    function automatic logic [7:0] filler_byte();
        if ($urandom_range(0, 1) != 0)
        begin
            return 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic deselect, input logic [7:0] tx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.command   <= deselect;
        item_ch.mosi_byte <= tx;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        expected_miso.push_back(predict_miso(deselect, tx));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] tx);
        send_item(1'b0, tx);
    endtask

    task automatic send_deselect();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_opcode_address(input logic [7:0] op, input logic [23:0] addr);
        send_byte(op);
        send_byte(addr[23:16]);
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_miso.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_status_regs(input logic [7:0] two, input logic [7:0] three);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sfcs_pkg::CFG_STATUS_TWO;
        cfg_ch.data  <= two;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        status_two_reg = two;
        cfg_ch.index <= sfcs_pkg::CFG_STATUS_THREE;
        cfg_ch.data  <= three;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        status_three_reg = three;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_status_registers();
        send_byte(sfcs_pkg::OP_WREN);
        send_byte(sfcs_pkg::OP_RDSR1);
        send_byte(8'h00);
        send_deselect();
        send_byte(sfcs_pkg::OP_RDSR2);
        send_byte(8'hFF);
        send_deselect();
        send_byte(sfcs_pkg::OP_RDSR3);
        send_byte(8'h00);
        send_deselect();
        send_byte(sfcs_pkg::OP_WRDI);
        send_byte(sfcs_pkg::OP_RDSR1);
        send_byte(8'hFF);
        send_deselect();
    endtask

    // The second data byte wraps to the start of the page, and the read starting at the
    // top of the 24-bit space wraps around to it.
    task automatic test_program_page_wrap();
        send_opcode_address(sfcs_pkg::OP_PROG, 24'h0000FF);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_deselect();
        send_opcode_address(sfcs_pkg::OP_READ, 24'hFFFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_deselect();
    endtask

    task automatic test_sleep_wake();
        send_byte(sfcs_pkg::OP_SLEEP);
        send_deselect();
        send_byte(sfcs_pkg::OP_JEDEC_ID);
        send_byte(8'h00);
        send_deselect();
        send_byte(sfcs_pkg::OP_WAKE);
        repeat (4) send_byte(8'h00);
        send_deselect();
    endtask

    task automatic send_random_frame();
        int         kind;
        logic [7:0] op;
        if (fm_asleep && $urandom_range(0, 3) != 0)
        begin
            send_byte(sfcs_pkg::OP_WAKE);
            send_deselect();
        end
        kind = $urandom_range(0, 99);
        if (kind < 18)
        begin
            send_opcode_address(sfcs_pkg::OP_READ, pick_address());
            repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 36)
        begin
            send_opcode_address(sfcs_pkg::OP_PROG, pick_address());
            repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 44)
        begin
            case ($urandom_range(0, 2))
                0:       op = sfcs_pkg::OP_RDSR1;
                1:       op = sfcs_pkg::OP_RDSR2;
                default: op = sfcs_pkg::OP_RDSR3;
            endcase
            send_byte(op);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 50)
        begin
            send_byte(($urandom_range(0, 1) != 0) ? sfcs_pkg::OP_WREN : sfcs_pkg::OP_WRDI);
        end
        else if (kind < 60)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    send_byte(sfcs_pkg::OP_UID);
                    repeat ($urandom_range(0, 14)) send_byte(filler_byte());
                end
                1:
                begin
                    send_opcode_address(sfcs_pkg::OP_MFR_ID, 24'($urandom));
                    repeat ($urandom_range(0, 3)) send_byte(filler_byte());
                end
                2:
                begin
                    send_byte(sfcs_pkg::OP_JEDEC_ID);
                    repeat ($urandom_range(0, 4)) send_byte(filler_byte());
                end
                default:
                begin
                    send_byte(sfcs_pkg::OP_WAKE);
                    repeat ($urandom_range(0, 5)) send_byte(filler_byte());
                end
            endcase
        end
        else if (kind < 65)
        begin
            case ($urandom_range(0, 2))
                0:       op = sfcs_pkg::OP_ERASE_4K;
                1:       op = sfcs_pkg::OP_ERASE_32K;
                default: op = sfcs_pkg::OP_ERASE_64K;
            endcase
            send_opcode_address(op, 24'($urandom));
        end
        else if (kind < 68)
        begin
            send_byte(sfcs_pkg::OP_SLEEP);
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            case ($urandom_range(0, 3))
                0:       op = sfcs_pkg::OP_READ;
                1:       op = sfcs_pkg::OP_PROG;
                2:       op = sfcs_pkg::OP_ERASE_4K;
                default: op = sfcs_pkg::OP_MFR_ID;
            endcase
            send_byte(op);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Several reply commands back to back can overrun the reply queue.
            repeat ($urandom_range(2, 4))
            begin
                case ($urandom_range(0, 4))
                    0:       send_byte(sfcs_pkg::OP_WREN);
                    1:       send_byte(sfcs_pkg::OP_WRDI);
                    2:       send_byte(sfcs_pkg::OP_UID);
                    3:       send_byte(sfcs_pkg::OP_JEDEC_ID);
                    default: send_byte(sfcs_pkg::OP_WAKE);
                endcase
            end
            repeat ($urandom_range(0, 20)) send_byte(filler_byte());
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_deselect();
        end
    endtask

    task automatic test_random_traffic(input int count, input int max_gap);
        int target;
        sender_max_gap = max_gap;
        target = items_sent + count;
        while (items_sent < target)
        begin
            send_random_frame();
        end
    endtask

    // The receiver holds off while a read stream keeps coming, so the block must stall its input.
    task automatic test_input_stall();
        sender_max_gap = 0;
        send_opcode_address(sfcs_pkg::OP_READ, pick_address());
        hold_request = 300;
        repeat (60) send_byte(8'($urandom_range(0, 255)));
        send_deselect();
    endtask

    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '0;
                1:       stall_pattern = $urandom & $urandom;
                2:       stall_pattern = $urandom;
                default: stall_pattern = $urandom | $urandom;
            endcase
        end
        stall_phase = (stall_phase + 1) % 160;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ~stall_pattern[0];
        end
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_miso.size() == 0)
            begin
                failure_count++;
                if (failure_count <= 10)
                begin
                    $display("Unexpected result transfer: miso_byte=%02h", result_ch.miso_byte);
                end
            end
            else
            begin
                checked_want = expected_miso.pop_front();
                if (result_ch.miso_byte !== checked_want)
                begin
                    failure_count++;
                    if (failure_count <= 10)
                    begin
                        $display("miso_byte mismatch: expected %02h, got %02h",
                                 checked_want, result_ch.miso_byte);
                    end
                end
            end
        end
    end

    initial
    begin
        while (watchdog_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.command   = 1'b0;
        item_ch.mosi_byte = 8'h00;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = sfcs_pkg::CFG_STATUS_TWO;
        cfg_ch.data       = 8'h00;
        reset_flash_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_status_regs(8'h00, 8'hFF);
        test_status_registers();
        test_program_page_wrap();
        test_sleep_wake();
        wait_idle();

        write_status_regs(8'hFF, 8'h00);
        test_status_registers();
        test_random_traffic(700, 0);
        wait_idle();

        write_status_regs(8'($urandom), 8'($urandom));
        test_random_traffic(700, 8);
        wait_idle();

        write_status_regs(8'($urandom), 8'($urandom));
        test_random_traffic(600, 2);
        test_input_stall();
        wait_idle();

        if (failure_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sfcs_pkg.sv
sv/sfcs_if.sv
sv/spi_flash_command_slave.sv
sim/tb_top.sv
